// ===== hw/rtl/gyro_shake_jab_detector_assert.svh =====
// Assertion macros for the gyro shake and jab detector.
// Expects clk and arst_n in the scope of each use.
`ifndef GYRO_SHAKE_JAB_DETECTOR_ASSERT_SVH
`define GYRO_SHAKE_JAB_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define GSJD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GSJD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gsjd_pkg.sv =====
// Shared types and constants of the gyro shake and jab detector.
// No dependencies.
package gsjd_pkg;

	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;
	localparam logic [15:0] MOVE_MIN = 16'd26;
	localparam logic [23:0] REST_ZERO_MAX = 24'd2;
	localparam logic [23:0] LEVEL_MAX = 24'hFF_FFFF;
	localparam logic [16:0] YZ_JAB_THRESHOLD = 17'd2560;
	localparam logic [15:0] JAB_THRESHOLD_RST = 16'd2560;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_JAB_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAK_PERIOD = 2'd1;

	localparam int IN_W = 80;
	localparam int OUT_W = 128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_MERGE
	} state_t;

	typedef struct packed {
		logic wr;
		logic div_lvl;
		logic div_abs;
		logic upd;
		logic acc_en;
		logic acc_first;
	} lane_ctl_t;

	typedef struct packed {
		logic [23:0]        level;
		logic signed [15:0] min_v;
		logic signed [15:0] max_v;
	} lane_res_t;

endpackage

// ===== hw/rtl/gsjd_lane.sv =====
// One axis lane: sample window memory with min/max scan and leaky shake level.
// Depends on gsjd_pkg.
module gsjd_lane #(
	parameter int WINDOW = 16,
	parameter int AW = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gsjd_pkg::lane_ctl_t      ctl,
	input  logic signed [15:0]       sample,
	input  logic [31:0]              time_ms,
	input  logic [9:0]               leak_period,
	input  logic [AW-1:0]            wr_addr,
	input  logic [AW-1:0]            rd_addr,
	output gsjd_pkg::lane_res_t      res
);
	import gsjd_pkg::*;

	logic signed [15:0] mem [WINDOW];
	logic signed [15:0] rd_data_q;
	logic signed [15:0] min_q, max_q;

	logic [23:0] shake_q;
	logic [31:0] last_leak_q;
	logic        leak_q, move_q;
	logic [15:0] abs_q;
	logic [26:0] num_q;
	logic [23:0] q_lvl_q;
	logic [11:0] q_abs_q;

	logic [15:0] abs_w;
	logic [31:0] elapsed_w;
	logic        leak_w, move_w;
	logic [26:0] lvl6_w, lvl3_w, mul_in_w;
	logic [58:0] prod_w;
	logic [23:0] quo_w, base_w, nv_w;
	logic [24:0] sum_w;

	always_ff @(posedge clk) begin
		if (ctl.wr)
			mem[wr_addr] <= sample;
		rd_data_q <= mem[rd_addr];
	end

	assign abs_w     = sample[15] ? (~sample + 16'd1) : sample;
	assign move_w    = abs_w >= MOVE_MIN;
	assign elapsed_w = time_ms - last_leak_q;
	assign leak_w    = (leak_period == 10'd0) || (elapsed_w >= {22'd0, leak_period});
	assign lvl6_w    = {1'b0, shake_q, 2'b00} + {2'b00, shake_q, 1'b0};
	assign lvl3_w    = {2'b00, shake_q, 1'b0} + {3'b000, shake_q};

	assign mul_in_w = ctl.div_abs ? {11'd0, abs_q} : num_q;
	assign prod_w   = 59'(mul_in_w) * 59'(RECIP_10);
	assign quo_w    = 24'(prod_w >> RECIP_SHIFT);

	always_comb begin
		base_w = leak_q ? q_lvl_q : shake_q;
		sum_w  = move_q ? (25'(base_w) + 25'(q_abs_q)) : 25'(base_w);
		if (!move_q && base_w <= REST_ZERO_MAX)
			nv_w = 24'd0;
		else if (sum_w[24])
			nv_w = LEVEL_MAX;
		else
			nv_w = sum_w[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shake_q     <= 24'd0;
			last_leak_q <= 32'd0;
		end else begin
			if (ctl.wr && leak_w && leak_period != 10'd0)
				last_leak_q <= time_ms;
			if (ctl.upd)
				shake_q <= nv_w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			leak_q <= leak_w;
			move_q <= move_w;
			abs_q  <= abs_w;
			num_q  <= move_w ? lvl6_w : lvl3_w;
		end
		if (ctl.div_lvl)
			q_lvl_q <= quo_w;
		if (ctl.div_abs)
			q_abs_q <= quo_w[11:0];
		if (ctl.acc_en) begin
			if (ctl.acc_first || rd_data_q < min_q)
				min_q <= rd_data_q;
			if (ctl.acc_first || rd_data_q > max_q)
				max_q <= rd_data_q;
		end
	end

	assign res.level = shake_q;
	assign res.min_v = min_q;
	assign res.max_v = max_q;

endmodule

// ===== hw/rtl/gsjd_merge.sv =====
// Merge stage: jab values from the lane ranges, held X jab and the result register.
// Depends on gsjd_pkg.
module gsjd_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  gsjd_pkg::lane_res_t     res [3],
	input  logic [15:0]             jab_threshold,
	output logic                    out_busy,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// shake_x[23:0], shake_y[47:24], shake_z[71:48], jab_x[88:72],
	// jab_y[104:89], jab_z[120:105], zero[127:121]
	output logic [gsjd_pkg::OUT_W-1:0] m_tdata
);
	import gsjd_pkg::*;

	logic signed [16:0] range_w [3];
	logic signed [16:0] jab_x_w, held_q;
	logic [15:0]        jab_y_w, jab_z_w;

	always_comb begin
		for (int i = 0; i < 3; i++)
			range_w[i] = {res[i].max_v[15], res[i].max_v} - {res[i].min_v[15], res[i].min_v};
		jab_x_w = held_q;
		if (range_w[0] > $signed({1'b0, jab_threshold})) begin
			if (!res[0].min_v[15])
				jab_x_w = range_w[0];
			else if (res[0].max_v[15])
				jab_x_w = -range_w[0];
			else
				jab_x_w = 17'sd0;
		end
		jab_y_w = (range_w[1] > $signed(YZ_JAB_THRESHOLD)) ? range_w[1][15:0] : 16'd0;
		jab_z_w = (range_w[2] > $signed(YZ_JAB_THRESHOLD)) ? range_w[2][15:0] : 16'd0;
	end

	assign out_busy = m_tvalid && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 17'sd0;
			m_tvalid <= 1'b0;
		end else if (load) begin
			held_q   <= jab_x_w;
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			m_tdata <= {7'd0, jab_z_w, jab_y_w, jab_x_w,
				res[2].level, res[1].level, res[0].level};
	end

endmodule

// ===== hw/rtl/gyro_shake_jab_detector.sv =====
// Top level of the gyro shake and jab detector: control sequencer, three axis lanes, merge.
// Depends on gsjd_pkg, gsjd_lane, gsjd_merge and the assertion macro header.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: gyro_x, gyro_y, gyro_z, time_ms
// m_       out  m_tvalid/m_tready    m_tdata: shake_x/y/z, jab_x/y/z
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From accept to the next s_tready a request passes the write, the window scan (one
// memory read per cycle over the valid entries), a drain step and the merge step.
// A new request is accepted only when the sequencer is back in its idle state.
// The result register lets the next request start while a result waits on m_tready.
// Reset clears levels, leak times, held X jab, window fill and head; no clearing pass.
// A stalled m_ side holds the sequencer in its merge step.
`include "gyro_shake_jab_detector_assert.svh"
module gyro_shake_jab_detector #(
	parameter int WINDOW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// gyro_x[15:0], gyro_y[31:16], gyro_z[47:32], time_ms[79:48]
	input  logic [gsjd_pkg::IN_W-1:0]      s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// shake_x[23:0], shake_y[47:24], shake_z[71:48], jab_x[88:72],
	// jab_y[104:89], jab_z[120:105], zero[127:121]
	output logic [gsjd_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gsjd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import gsjd_pkg::*;

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW = $clog2(WINDOW + 1);

	state_t state_q, state_d;

	logic signed [15:0] gyro_q [3];
	logic [31:0]        time_q;
	logic [15:0]        jab_threshold_q;
	logic [9:0]         leak_period_q;
	logic [AW-1:0]      head_q, scan_cnt_q;
	logic [FW-1:0]      fill_q;
	logic               acc_vld_s1, acc_first_s1;
	logic               sh_s1, sh_s2, sh_s3;
	logic               scan_last, pipe_busy, out_busy, load;
	lane_ctl_t          ctl;
	lane_res_t          res [3];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign scan_last = (FW'(scan_cnt_q) == fill_q - FW'(1));
	assign pipe_busy = sh_s1 || sh_s2 || sh_s3;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_MERGE;
			ST_MERGE: if (!pipe_busy && !out_busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.wr        = (state_q == ST_WRITE);
		ctl.div_lvl   = sh_s1;
		ctl.div_abs   = sh_s2;
		ctl.upd       = sh_s3;
		ctl.acc_en    = acc_vld_s1;
		ctl.acc_first = acc_first_s1;
		load          = (state_q == ST_MERGE) && !pipe_busy && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			head_q          <= '0;
			fill_q          <= '0;
			scan_cnt_q      <= '0;
			acc_vld_s1      <= 1'b0;
			acc_first_s1    <= 1'b0;
			sh_s1           <= 1'b0;
			sh_s2           <= 1'b0;
			sh_s3           <= 1'b0;
			jab_threshold_q <= JAB_THRESHOLD_RST;
			leak_period_q   <= 10'd0;
		end else begin
			state_q      <= state_d;
			acc_vld_s1   <= (state_q == ST_SCAN);
			acc_first_s1 <= (state_q == ST_SCAN) && (scan_cnt_q == '0);
			sh_s1        <= (state_q == ST_WRITE);
			sh_s2        <= sh_s1;
			sh_s3        <= sh_s2;
			if (state_q == ST_WRITE) begin
				head_q     <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + AW'(1);
				scan_cnt_q <= '0;
				if (fill_q < FW'(WINDOW))
					fill_q <= fill_q + FW'(1);
			end else if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_JAB_THRESHOLD: jab_threshold_q <= cfg_data;
					CFG_LEAK_PERIOD:   leak_period_q   <= cfg_data[9:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			gyro_q[0] <= s_tdata[15:0];
			gyro_q[1] <= s_tdata[31:16];
			gyro_q[2] <= s_tdata[47:32];
			time_q    <= s_tdata[79:48];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		gsjd_lane #(
			.WINDOW (WINDOW),
			.AW     (AW)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.sample      (gyro_q[g]),
			.time_ms     (time_q),
			.leak_period (leak_period_q),
			.wr_addr     (head_q),
			.rd_addr     (scan_cnt_q),
			.res         (res[g])
		);
	end

	gsjd_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.res           (res),
		.jab_threshold (jab_threshold_q),
		.out_busy      (out_busy),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

	`GSJD_ASSERT_NXT(a_accept_to_write, s_tvalid && s_tready, state_q == ST_WRITE, "accept did not start a write")
	`GSJD_ASSERT_IMP(a_scan_in_fill, state_q == ST_SCAN, FW'(scan_cnt_q) < fill_q, "scan read beyond window fill")
	`GSJD_ASSERT_IMP(a_load_after_shake, load, !pipe_busy && !acc_vld_s1, "result loaded before lanes settled")
	`GSJD_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FW'(WINDOW), "window fill exceeds depth")

endmodule

// ===== dv/tb_gyro_shake_jab_detector.sv =====
// Self-checking testbench for gyro_shake_jab_detector: directed and random gyro samples
// over the stream ports, with a built-in predictor of shake levels and jab values.
// Depends on gsjd_pkg and the detector RTL.
`timescale 1ns / 100ps
module tb_gyro_shake_jab_detector;
	import gsjd_pkg::*;

	localparam int WINDOW = 16;
	localparam int CLK_HALF = 6;
	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int SETTLE_CYCLES = WINDOW + 8;
	localparam int WANT_DEPTH = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_B = 2'd3;

	typedef struct packed {
		logic [23:0] shake_x;
		logic [23:0] shake_y;
		logic [23:0] shake_z;
		logic [16:0] jab_x;
		logic [15:0] jab_y;
		logic [15:0] jab_z;
	} shake_jab_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	// predictor state
	logic signed [15:0] win [3][WINDOW];
	int                 fill = 0;
	int                 head = 0;
	logic [23:0]        level [3] = '{default: '0};
	logic [31:0]        last_leak [3] = '{default: '0};
	logic signed [16:0] held_jab_x = '0;
	logic [15:0]        jab_thr = JAB_THRESHOLD_RST;
	logic [9:0]         leak_period = '0;

	shake_jab_t want_mem [WANT_DEPTH];
	int         want_wr = 0;
	int         want_rd = 0;
	int         want_count = 0;
	int         error_count = 0;
	int         cycle_count = 0;
	bit         tx_idle = 1'b1;
	bit         rx_idle = 1'b1;
	int         rx_hold = 0;
	logic [31:0] clock_ms = '0;
	int         ctr [3] = '{default: 0};
	int         spr [3] = '{default: 100};
	int         burst_left = 0;

	gyro_shake_jab_detector #(
		.WINDOW(WINDOW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic want_put(input shake_jab_t v);
		if (want_count == WANT_DEPTH) begin
			$error("expected result store overflow");
			error_count++;
		end else begin
			want_mem[want_wr] = v;
			want_wr = (want_wr + 1) % WANT_DEPTH;
			want_count++;
		end
	endtask

	function automatic shake_jab_t want_take();
		shake_jab_t v;
		v = want_mem[want_rd];
		want_rd = (want_rd + 1) % WANT_DEPTH;
		want_count--;
		return v;
	endfunction

	function automatic shake_jab_t compute_shake_jab(input logic signed [15:0] gx,
			input logic signed [15:0] gy, input logic signed [15:0] gz, input logic [31:0] t);
		shake_jab_t         r;
		logic signed [15:0] s [3];
		int                 mag, mn, mx, rng;
		int                 jab_rng [3];
		longint unsigned    lv, nv;
		logic [31:0]        elapsed;
		bit                 leak;
		s[0] = gx;
		s[1] = gy;
		s[2] = gz;
		for (int ax = 0; ax < 3; ax++)
			win[ax][head] = s[ax];
		head = (head + 1 >= WINDOW) ? 0 : head + 1;
		if (fill < WINDOW)
			fill++;
		for (int ax = 0; ax < 3; ax++) begin
			mag = (s[ax] < 0) ? -int'(s[ax]) : int'(s[ax]);
			leak = 1'b1;
			if (leak_period != 0) begin
				elapsed = t - last_leak[ax];
				if (elapsed < leak_period)
					leak = 1'b0;
				else
					last_leak[ax] = t;
			end
			lv = level[ax];
			if (mag >= MOVE_MIN) begin
				nv = longint'(mag / 10) + (leak ? (lv * 6) / 10 : lv);
			end else begin
				nv = leak ? (lv * 3) / 10 : lv;
				if (nv <= REST_ZERO_MAX)
					nv = 0;
			end
			if (nv > LEVEL_MAX)
				nv = LEVEL_MAX;
			level[ax] = nv[23:0];
			mn = win[ax][0];
			mx = mn;
			for (int i = 0; i < fill; i++) begin
				if (win[ax][i] < mn)
					mn = win[ax][i];
				if (win[ax][i] > mx)
					mx = win[ax][i];
			end
			rng = mx - mn;
			jab_rng[ax] = rng;
			if (ax == 0 && rng > jab_thr) begin
				if (mn >= 0)
					held_jab_x = 17'(mx - mn);
				else if (mx < 0)
					held_jab_x = 17'(mn - mx);
				else
					held_jab_x = '0;
			end
		end
		r.shake_x = level[0];
		r.shake_y = level[1];
		r.shake_z = level[2];
		r.jab_x = held_jab_x;
		r.jab_y = (jab_rng[1] > YZ_JAB_THRESHOLD) ? 16'(jab_rng[1]) : 16'd0;
		r.jab_z = (jab_rng[2] > YZ_JAB_THRESHOLD) ? 16'(jab_rng[2]) : 16'd0;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_rate(input int center, input int spread);
		int v;
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		shake_jab_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (want_count == 0) begin
				$error("result with nothing expected: %0h", m_tdata);
				error_count++;
			end else begin
				want = want_take();
				check_field("shake_x", want.shake_x, m_tdata[23:0]);
				check_field("shake_y", want.shake_y, m_tdata[47:24]);
				check_field("shake_z", want.shake_z, m_tdata[71:48]);
				check_field("jab_x", 24'(want.jab_x), 24'(m_tdata[88:72]));
				check_field("jab_y", 24'(want.jab_y), 24'(m_tdata[104:89]));
				check_field("jab_z", 24'(want.jab_z), 24'(m_tdata[120:105]));
				check_field("pad", 24'd0, 24'(m_tdata[127:121]));
			end
		end
	end

	initial begin
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (!rx_idle) begin
				m_tready <= 1'b1;
			end else begin
				if (stall_left == 0 && run_left == 0) begin
					if ($urandom_range(0, 2) == 0)
						stall_left = $urandom_range(1, 13);
					else
						run_left = $urandom_range(1, 24);
				end
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
					run_left--;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_JAB_THRESHOLD)
			jab_thr = val;
		else if (idx == CFG_LEAK_PERIOD)
			leak_period = val[9:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic signed [15:0] gx, input logic signed [15:0] gy,
			input logic signed [15:0] gz, input logic [31:0] t);
		int gap;
		gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {t, gz, gy, gx};
		do @(posedge clk); while (!s_tready);
		want_put(compute_shake_jab(gx, gy, gz, t));
	endtask

	task automatic send_random_sample();
		logic signed [15:0] g [3];
		if (burst_left == 0) begin
			burst_left = $urandom_range(4, 40);
			for (int ax = 0; ax < 3; ax++) begin
				case ($urandom_range(0, 5))
					0: ctr[ax] = -20000;
					1: ctr[ax] = -3000;
					2: ctr[ax] = 0;
					3: ctr[ax] = 3000;
					4: ctr[ax] = 20000;
					default: ctr[ax] = int'($urandom_range(0, 60000)) - 30000;
				endcase
				case ($urandom_range(0, 3))
					0: spr[ax] = 20;
					1: spr[ax] = 300;
					2: spr[ax] = 3000;
					default: spr[ax] = 32767;
				endcase
			end
		end
		burst_left--;
		for (int ax = 0; ax < 3; ax++)
			g[ax] = pick_rate(ctr[ax], spr[ax]);
		case ($urandom_range(0, 11))
			0: clock_ms = $urandom;
			1: clock_ms = clock_ms;
			2: clock_ms = clock_ms + $urandom_range(900, 1100);
			default: clock_ms = clock_ms + $urandom_range(0, 400);
		endcase
		send_sample(g[0], g[1], g[2], clock_ms);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (want_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_threshold_edges();
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
		send_sample(16'sd2560, 16'sd2560, -16'sd2560, 32'd1);
		send_sample(16'sd2561, 16'sd2561, -16'sd2561, 32'd2);
		send_sample(16'sd32767, -16'sd32768, 16'sd25, 32'd3);
		send_sample(-16'sd32768, 16'sd32767, -16'sd26, 32'd4);
		send_sample(16'sd26, -16'sd25, -16'sd1, 32'd5);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd6);
		wait_drained();
	endtask

	task automatic test_leak_timing();
		write_reg(CFG_LEAK_PERIOD, 16'd100);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'd50);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'd99);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'd100);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'd150);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'hFFFF_FFF0);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'h0000_0020);
		send_sample(16'sd1000, -16'sd1000, 16'sd500, 32'h0000_0060);
		send_sample(16'sd3, -16'sd3, 16'sd0, 32'h0000_0061);
		wait_drained();
	endtask

	task automatic test_register_masking();
		write_reg(CFG_LEAK_PERIOD, 16'hFFFF);
		send_sample(16'sd12000, 16'sd12000, 16'sd12000, 32'h0000_0400);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_0460);
		wait_drained();
		write_reg(CFG_NO_REG_A, 16'($urandom));
		write_reg(CFG_NO_REG_B, 16'($urandom));
		send_sample(-16'sd7000, 16'sd100, -16'sd100, 32'h0000_0900);
		wait_drained();
	endtask

	task automatic test_jab_threshold_extremes();
		write_reg(CFG_JAB_THRESHOLD, 16'd0);
		write_reg(CFG_LEAK_PERIOD, 16'd0);
		send_sample(-16'sd20000, 16'sd0, 16'sd0, 32'd10);
		send_sample(16'sd20000, 16'sd0, 16'sd0, 32'd11);
		wait_drained();
		write_reg(CFG_JAB_THRESHOLD, 16'hFFFF);
		send_sample(-16'sd32768, 16'sd0, 16'sd0, 32'd12);
		send_sample(16'sd32767, 16'sd0, 16'sd0, 32'd13);
		wait_drained();
	endtask

	task automatic test_full_scale_rates();
		logic signed [15:0] g [3];
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_reg(CFG_LEAK_PERIOD, 16'd1000);
		clock_ms = 32'h8000_0000;
		for (int n = 0; n < 40; n++) begin
			for (int ax = 0; ax < 3; ax++)
				g[ax] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			send_sample(g[0], g[1], g[2], clock_ms);
		end
		wait_drained();
		write_reg(CFG_LEAK_PERIOD, 16'd0);
		for (int n = 0; n < 4; n++)
			send_sample(16'sd0, 16'sd10, -16'sd10, clock_ms);
		wait_drained();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_random_phases(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 3))
				0: write_reg(CFG_JAB_THRESHOLD, 16'd0);
				1: write_reg(CFG_JAB_THRESHOLD, 16'hFFFF);
				2: write_reg(CFG_JAB_THRESHOLD, JAB_THRESHOLD_RST);
				default: write_reg(CFG_JAB_THRESHOLD, 16'($urandom_range(0, 12000)));
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(CFG_LEAK_PERIOD, 16'd0);
				1: write_reg(CFG_LEAK_PERIOD, 16'd1);
				2: write_reg(CFG_LEAK_PERIOD, 16'd1000);
				3: write_reg(CFG_LEAK_PERIOD, 16'd1023);
				default: write_reg(CFG_LEAK_PERIOD, 16'($urandom));
			endcase
			for (int n = 0; n < per_phase; n++)
				send_random_sample();
			wait_drained();
		end
	endtask

	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_hold = 400;
		for (int n = 0; n < 30; n++)
			send_random_sample();
		wait_drained();
		tx_idle = 1'b1;
	endtask

	task automatic test_unpaced_stream();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_reg(CFG_JAB_THRESHOLD, 16'd1500);
		write_reg(CFG_LEAK_PERIOD, 16'd200);
		for (int n = 0; n < 60; n++)
			send_random_sample();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_threshold_edges();
		test_leak_timing();
		test_register_masking();
		test_jab_threshold_extremes();
		test_full_scale_rates();
		test_random_phases(4, 75);
		test_output_backpressure();
		test_random_phases(4, 75);
		test_unpaced_stream();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
